// ----- design/hmq_pkg.sv -----
// Shared types and codes for the binary max heap queue.
// Used by the heap cell and the top level; depends on nothing else.
`timescale 1ns / 1ps

package hmq_pkg;

  // Key width and the width of the reported entry count.
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 8;

  // Operation codes carried in the input beat.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Input beat: one operation.
  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] value;
  } in_beat_t;

  // Result beat: heap status after the operation.
  typedef struct packed {
    logic signed [KEY_W-1:0] top_value;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
    logic                    op_error;
  } out_beat_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

// ----- design/hmq_cell.sv -----
// One cell of the sorted key chain: holds one key and trades with its neighbors.
// Depends on hmq_pkg for the command type and key width.
`timescale 1ns / 1ps

module hmq_cell (
  input  logic                            clk,
  input  hmq_pkg::cell_cmd_t              cmd,
  input  logic                            occ,
  input  logic                            left_ge,
  input  logic signed [hmq_pkg::KEY_W-1:0] left_key,
  input  logic signed [hmq_pkg::KEY_W-1:0] right_key,
  output logic signed [hmq_pkg::KEY_W-1:0] key,
  output logic                            ge
);
  import hmq_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  // The held key stays in place on insert when it is not below the new key.
  assign ge  = occ && (key_r >= cmd.key);
  assign key = key_r;

  // Insert shifts smaller keys one cell to the right; remove shifts left.
  always_comb begin
    key_nxt = key_r;
    if (cmd.ins && !ge) begin
      key_nxt = left_ge ? cmd.key : left_key;
    end else if (cmd.rem) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- design/binary_max_heap_queue.sv -----
// Top level of the max priority queue: a chain of key cells kept in sorted order.
// Depends on hmq_pkg and hmq_cell.
//
//   Channel | Ports                          | Beat
//   input   | in_valid, in_stall, in_data    | in_beat_t: operation, value
//   result  | out_valid, out_stall, out_data | out_beat_t: top, count, empty, error
//
// In the accept cycle every cell updates at once; in the report state the
// result register then loads the head cell and the count once the result is free.
// An item is accepted only while no earlier item is still being reported.
// Reset clears the count, the state and the result valid; no clearing pass.
// A stalled result holds the next item in the report cycle until it is taken.
`timescale 1ns / 1ps

module binary_max_heap_queue #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hmq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hmq_pkg::out_beat_t out_data
);
  import hmq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REPORT = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  logic          in_acc;
  logic          is_full;
  logic          load_out;
  cell_cmd_t     cmd;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic                    cell_ge  [CAPACITY];
  logic                    cell_occ [CAPACITY];

  logic [CW+COUNT_W-1:0]   count_wide;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_full  = (count_r == CW'(CAPACITY));

  // Decode the beat into a command that every cell sees.
  always_comb begin
    cmd.ins = in_acc && (in_data.operation == OP_INSERT) && !is_full;
    cmd.rem = in_acc && (in_data.operation == OP_REMOVE) && (count_r != '0);
    cmd.key = in_data.value;
  end

  // Chain of cells, largest key in cell zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = (CW'(i) < count_r);
    if (i == 0) begin : g_head
      hmq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (cell_occ[i]),
        .left_ge   (1'b1),
        .left_key  ('0),
        .right_key ((CAPACITY > 1) ? cell_key[(CAPACITY > 1) ? 1 : 0] : '0),
        .key       (cell_key[i]),
        .ge        (cell_ge[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      hmq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (cell_occ[i]),
        .left_ge   (cell_ge[i-1]),
        .left_key  (cell_key[i-1]),
        .right_key ('0),
        .key       (cell_key[i]),
        .ge        (cell_ge[i])
      );
    end else begin : g_mid
      hmq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (cell_occ[i]),
        .left_ge   (cell_ge[i-1]),
        .left_key  (cell_key[i-1]),
        .right_key (cell_key[i+1]),
        .key       (cell_key[i]),
        .ge        (cell_ge[i])
      );
    end
  end

  // Count, error flag and sequencing.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          err_nxt   = !(cmd.ins || cmd.rem);
          state_nxt = ST_REPORT;
          if (cmd.ins) begin
            count_nxt = count_r + CW'(1);
          end else if (cmd.rem) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      ST_REPORT: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register: loaded from the head cell once the cells have settled.
  assign load_out   = (state_r == ST_REPORT) && (!out_valid_r || !out_stall);
  assign count_wide = {{COUNT_W{1'b0}}, count_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.top_value   = (count_r != '0) ? cell_key[0] : '0;
      out_data_nxt.entry_count = count_wide[COUNT_W-1:0];
      out_data_nxt.is_empty    = (count_r == '0);
      out_data_nxt.op_error    = err_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // An insert that is taken grows the count by exactly one.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the count by one");

  // An error is only reported with an empty or a full heap.
  a_err_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && err_r) |-> (count_r == '0 || count_r == CW'(CAPACITY)))
    else $error("error flag with a heap that is neither empty nor full");

  // When the chain is full, the head cell holds a key no smaller than the last cell's key.
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPORT && cell_occ[CAPACITY-1] && CAPACITY > 1)
      |-> (cell_key[0] >= cell_key[CAPACITY-1]))
    else $error("head key below the last key");

  // An empty heap reports a zero key.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_empty) |-> (out_data_r.top_value == '0))
    else $error("empty heap reported a nonzero key");
`endif

endmodule
